FILE: src/pfcm_pkg.sv
// Package: shared types, constants and a helper function of the feature crossing mapper.
package pfcm_pkg;

   localparam int MAX_FEATURES_DEF = 64;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int MODE_W   = 4;
   localparam int COUNT_W  = 7;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 13;
   localparam int SUM_W    = 48;
   localparam int CSR_ADDR_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_AND      = 4'd0,
      MODE_OR       = 4'd1,
      MODE_XOR      = 4'd2,
      MODE_AND_OR   = 4'd3,
      MODE_MUL      = 4'd4,
      MODE_ADD      = 4'd5,
      MODE_AVERAGE  = 4'd6,
      MODE_NEGATE   = 4'd7,
      MODE_INTERVAL = 4'd8
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MAP_MODE       = 2'd0,
      CSR_FEATURE_COUNT  = 2'd1,
      CSR_INTERVAL_START = 2'd2,
      CSR_INTERVAL_END   = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // store the accepted feature
      logic read;       // read operands for the next output
      logic calc;       // form the result from read operands
      logic mul_fin;    // finish product shift
      logic div_start;  // start the mean division
      logic div_step;   // one division step
      logic emit;       // produce result / advance walk
      logic empty;      // produce nothing_pending result
      logic out_take;   // output register taken
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pending;    // an output is available
      logic need_mul;   // current output goes through the product shift
      logic need_div;   // current output is the mean
      logic div_done;
      logic out_full;
   } status_type;

   function automatic logic [VALUE_W-1:0] sat32(input logic signed [SUM_W+1:0] v);
      logic signed [SUM_W+1:0] hi;
      logic signed [SUM_W+1:0] lo;
      hi = (SUM_W+2)'(signed'(64'sh7FFF_FFFF));
      lo = -(SUM_W+2)'(signed'(64'sh8000_0000));
      if (v > hi)       sat32 = 32'h7FFF_FFFF;
      else if (v < lo)  sat32 = 32'h8000_0000;
      else              sat32 = v[VALUE_W-1:0];
   endfunction

endpackage

FILE: src/pfcm_if.sv
// Interface: valid/ready channel carrying one item.
interface pfcm_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/pairwise_feature_crossing_mapper_core.sv
// Top level of the pairwise feature crossing mapper.
// A load item (func 0) stores one signed fixed-point feature and produces no result; loads
// are taken one per cycle while no fetch is in progress and the output register is empty.
// A fetch item (func 1) yields exactly one result: the next mapped feature, or a result
// with nothing_pending set when none is available. A fetch passes through accept, read,
// calculate and output steps before its result is offered. Multiply and interval add a
// step for the registered product shift. The average entry runs a serial divider that
// forms one quotient bit of the 48-bit sum per cycle, plus a step to finish. A fetch
// with nothing pending skips the arithmetic: its result is offered in the cycle after
// it is taken.
// The block holds one result in its output register; a new item is taken once that
// register has been emptied, so a stalled receiver stalls the input as well.
// Configuration may be written only while the block is idle; a write to map_mode or
// feature_count discards the record in progress.
module pairwise_feature_crossing_mapper_core #(
   parameter int MAX_FEATURES = pfcm_pkg::MAX_FEATURES_DEF,
   parameter int FRAC_BITS    = pfcm_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pfcm_if.sink                            req,
   pfcm_if.source                          rsp,
   input  logic                            csr_we,
   input  logic [pfcm_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [pfcm_pkg::VALUE_W-1:0]    csr_data
);
   pfcm_pkg::cmd_type    cmd;
   pfcm_pkg::status_type sts;

   // Request payload: {func, feature_value}; response: {mapped, index, last, none}.
   pfcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_func  (req.data[pfcm_pkg::VALUE_W]),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfcm_dp #(
      .MAX_FEATURES (MAX_FEATURES),
      .FRAC_BITS    (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .feature_value   (req.data[pfcm_pkg::VALUE_W-1:0]),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mapped_value    (rsp.data[46:15]),
      .out_index       (rsp.data[14:2]),
      .last_of_record  (rsp.data[1]),
      .nothing_pending (rsp.data[0])
   );

   assign rsp.valid = sts.out_full;
endmodule

FILE: src/pfcm_ctrl.sv
// Controller: state machine sequencing loads, fetches and the mean division.
module pfcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   input  logic                rsp_ready,
   input  pfcm_pkg::status_type sts,
   output pfcm_pkg::cmd_type    cmd
);
   pfcm_pkg::state_type state_ff, state_in;
   logic acc;

   assign acc = req_valid && req_ready;
   assign req_ready = (state_ff == pfcm_pkg::ST_IDLE) && !sts.out_full;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfcm_pkg::ST_IDLE: begin
            if (acc && req_func && sts.pending) state_in = pfcm_pkg::ST_READ;
         end
         pfcm_pkg::ST_READ: state_in = pfcm_pkg::ST_CALC;
         pfcm_pkg::ST_CALC: begin
            if (sts.need_div)      state_in = pfcm_pkg::ST_DIV;
            else if (sts.need_mul) state_in = pfcm_pkg::ST_MUL;
            else                   state_in = pfcm_pkg::ST_OUT;
         end
         pfcm_pkg::ST_MUL: state_in = pfcm_pkg::ST_OUT;
         pfcm_pkg::ST_DIV: begin
            if (sts.div_done) state_in = pfcm_pkg::ST_OUT;
         end
         pfcm_pkg::ST_OUT: state_in = pfcm_pkg::ST_IDLE;
         default: state_in = pfcm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.out_take = sts.out_full && rsp_ready;
      unique case (state_ff)
         pfcm_pkg::ST_IDLE: begin
            cmd.load  = acc && !req_func;
            cmd.empty = acc && req_func && !sts.pending;
            cmd.read  = acc && req_func && sts.pending;
         end
         pfcm_pkg::ST_CALC: begin
            cmd.calc      = 1'b1;
            cmd.div_start = sts.need_div;
         end
         pfcm_pkg::ST_MUL: cmd.mul_fin  = 1'b1;
         pfcm_pkg::ST_DIV: cmd.div_step = 1'b1;
         pfcm_pkg::ST_OUT: cmd.emit     = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pfcm_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

FILE: src/pfcm_dp.sv
// Datapath: feature store, triangle walk, arithmetic, mean divider and output register.
module pfcm_dp #(
   parameter int MAX_FEATURES = pfcm_pkg::MAX_FEATURES_DEF,
   parameter int FRAC_BITS    = pfcm_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pfcm_pkg::cmd_type                 cmd,
   output pfcm_pkg::status_type              sts,
   input  logic [pfcm_pkg::VALUE_W-1:0]      feature_value,
   input  logic                              csr_we,
   input  logic [pfcm_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [pfcm_pkg::VALUE_W-1:0]      csr_data,
   output logic [pfcm_pkg::VALUE_W-1:0]      mapped_value,
   output logic [pfcm_pkg::INDEX_W-1:0]      out_index,
   output logic                              last_of_record,
   output logic                              nothing_pending
);
   localparam int AW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CW   = pfcm_pkg::COUNT_W;
   localparam int VW   = pfcm_pkg::VALUE_W;
   localparam int IW   = pfcm_pkg::INDEX_W;
   localparam int SW   = pfcm_pkg::SUM_W;
   localparam int TW   = 16;

   logic [pfcm_pkg::MODE_W-1:0] mode_ff;
   logic [CW-1:0]               fcount_ff;
   logic signed [VW-1:0]        istart_ff, iend_ff;

   logic [VW-1:0]        store_mem [MAX_FEATURES];
   logic [CW:0]          loaded_ff;
   logic [AW:0]          row_ff, col_ff;
   logic                 second_ff;
   logic signed [SW-1:0] sum_ff;
   logic [TW-1:0]        emitted_ff;

   logic [VW-1:0]        a_ff, b_ff;
   logic signed [VW:0]   span_ff;
   logic signed [SW+1:0] res_ff;
   logic signed [2*VW+1:0] prod_ff;

   logic [VW-1:0]        out_val_ff;
   logic [IW-1:0]        out_idx_ff;
   logic                 out_last_ff, out_none_ff, out_full_ff;

   // Serial restoring divider for the mean.
   logic [SW-1:0]        dquo_ff, drem_ff;
   logic [CW-1:0]        dcnt_ff;
   logic                 dneg_ff;

   logic [AW:0]          n;
   logic [TW-1:0]        total;
   logic                 valid_mode, pairwise, pending;
   logic [AW:0]          k_idx;

   always_comb begin
      if (fcount_ff == '0)                             n = (AW+1)'(1);
      else if (32'(fcount_ff) > MAX_FEATURES)          n = (AW+1)'(MAX_FEATURES);
      else                                             n = (AW+1)'(fcount_ff);
   end

   always_comb begin
      valid_mode = 1'b1;
      case (mode_ff)
         pfcm_pkg::MODE_AND, pfcm_pkg::MODE_OR, pfcm_pkg::MODE_XOR,
         pfcm_pkg::MODE_MUL, pfcm_pkg::MODE_ADD:
            total = TW'((32'(n) * (32'(n) + 32'd1)) >> 1);
         pfcm_pkg::MODE_AND_OR:   total = TW'(32'(n) * (32'(n) + 32'd1));
         pfcm_pkg::MODE_AVERAGE:  total = TW'(n) + TW'(1);
         pfcm_pkg::MODE_NEGATE, pfcm_pkg::MODE_INTERVAL: total = TW'(n);
         default: begin
            total = '0;
            valid_mode = 1'b0;
         end
      endcase
   end

   assign pairwise = mode_ff <= pfcm_pkg::MODE_ADD;
   assign pending  = valid_mode && (loaded_ff == (CW+1)'(n)) && (emitted_ff < total);
   assign k_idx    = emitted_ff[AW:0];

   assign sts.pending  = pending;
   assign sts.need_mul = (mode_ff == pfcm_pkg::MODE_MUL) || (mode_ff == pfcm_pkg::MODE_INTERVAL);
   assign sts.need_div = (mode_ff == pfcm_pkg::MODE_AVERAGE) && (emitted_ff >= TW'(n));
   assign sts.div_done = (dcnt_ff == '0);
   assign sts.out_full = out_full_ff;

   // Control registers and the record pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         fcount_ff  <= CW'(1);
         istart_ff  <= '0;
         iend_ff    <= VW'(65536);
         loaded_ff  <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         second_ff  <= 1'b0;
         sum_ff     <= '0;
         emitted_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               pfcm_pkg::CSR_MAP_MODE:       mode_ff   <= csr_data[pfcm_pkg::MODE_W-1:0];
               pfcm_pkg::CSR_FEATURE_COUNT:  fcount_ff <= csr_data[CW-1:0];
               pfcm_pkg::CSR_INTERVAL_START: istart_ff <= csr_data;
               pfcm_pkg::CSR_INTERVAL_END:   iend_ff   <= csr_data;
               default: ;
            endcase
            if (csr_index == pfcm_pkg::CSR_MAP_MODE ||
                csr_index == pfcm_pkg::CSR_FEATURE_COUNT) begin
               loaded_ff  <= '0;
               row_ff     <= '0;
               col_ff     <= '0;
               second_ff  <= 1'b0;
               sum_ff     <= '0;
               emitted_ff <= '0;
            end
         end
         if (cmd.load) begin
            if (loaded_ff >= (CW+1)'(n)) begin
               loaded_ff  <= (CW+1)'(1);
               row_ff     <= '0;
               col_ff     <= '0;
               second_ff  <= 1'b0;
               sum_ff     <= SW'(signed'(feature_value));
               emitted_ff <= '0;
            end else begin
               loaded_ff <= loaded_ff + (CW+1)'(1);
               sum_ff    <= sum_ff + SW'(signed'(feature_value));
            end
         end
         if (cmd.emit) begin
            emitted_ff <= emitted_ff + TW'(1);
            if (pairwise) begin
               if (mode_ff == pfcm_pkg::MODE_AND_OR && !second_ff) begin
                  second_ff <= 1'b1;
               end else begin
                  second_ff <= 1'b0;
                  if (col_ff + (AW+1)'(1) >= n) begin
                     row_ff <= row_ff + (AW+1)'(1);
                     col_ff <= row_ff + (AW+1)'(1);
                  end else begin
                     col_ff <= col_ff + (AW+1)'(1);
                  end
               end
            end
         end
      end
   end

   // Feature store: one write port and two registered read ports.
   logic [AW-1:0] wr_addr, rd_addr;
   assign wr_addr = (loaded_ff >= (CW+1)'(n)) ? '0 : loaded_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) store_mem[wr_addr] <= feature_value;
   end

   // Both operands are read at the edge that accepts the fetch.
   assign rd_addr = pairwise ? row_ff[AW-1:0] : k_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.read) a_ff <= store_mem[rd_addr];
      if (cmd.read) b_ff <= store_mem[col_ff[AW-1:0]];
      if (cmd.read) span_ff <= (VW+1)'(iend_ff) - (VW+1)'(istart_ff);
   end

   // Arithmetic.
   logic signed [VW-1:0]   sa, sb;
   logic [VW-1:0]          ia, ib, bits;
   logic signed [SW+1:0]   calc_v;
   logic signed [2*VW+1:0] prod_v;
   assign sa = a_ff;
   assign sb = b_ff;
   assign ia = sa[VW-1] ? '0 : VW'(sa >>> FRAC_BITS);
   assign ib = sb[VW-1] ? '0 : VW'(sb >>> FRAC_BITS);

   always_comb begin
      bits   = '0;
      calc_v = '0;
      prod_v = '0;
      case (mode_ff)
         pfcm_pkg::MODE_AND:    bits = ia & ib;
         pfcm_pkg::MODE_OR:     bits = ia | ib;
         pfcm_pkg::MODE_XOR:    bits = ia ^ ib;
         pfcm_pkg::MODE_AND_OR: bits = second_ff ? (ia | ib) : (ia & ib);
         default: ;
      endcase
      case (mode_ff)
         pfcm_pkg::MODE_AND, pfcm_pkg::MODE_OR, pfcm_pkg::MODE_XOR,
         pfcm_pkg::MODE_AND_OR:
            calc_v = (SW+2)'($unsigned({bits, {FRAC_BITS{1'b0}}}) & {(SW+2){1'b1}});
         pfcm_pkg::MODE_ADD:    calc_v = (SW+2)'(sa) + (SW+2)'(sb);
         pfcm_pkg::MODE_AVERAGE: calc_v = (SW+2)'(sa);
         pfcm_pkg::MODE_NEGATE:
            calc_v = ((SW+2)'(1) <<< FRAC_BITS) - (SW+2)'(sa);
         pfcm_pkg::MODE_MUL:      prod_v = (2*VW+2)'(sa) * (2*VW+2)'(sb);
         pfcm_pkg::MODE_INTERVAL: prod_v = (2*VW+2)'(sa) * (2*VW+2)'(span_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         res_ff  <= calc_v;
         prod_ff <= prod_v;
      end else if (cmd.mul_fin) begin
         if (mode_ff == pfcm_pkg::MODE_INTERVAL)
            res_ff <= (SW+2)'(prod_ff >>> FRAC_BITS) + (SW+2)'(istart_ff);
         else
            res_ff <= (SW+2)'(prod_ff >>> FRAC_BITS);
      end else if (cmd.div_step && dcnt_ff == '0) begin
         res_ff <= dneg_ff ? -(SW+2)'(dquo_ff) : (SW+2)'(dquo_ff);
      end
   end

   // Mean division: magnitude of the sum divided by n, one quotient bit a cycle.
   logic [SW:0] trial;
   assign trial = {drem_ff, dquo_ff[SW-1]} - (SW+1)'(n);

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dneg_ff <= sum_ff[SW-1];
         dquo_ff <= sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
         drem_ff <= '0;
         dcnt_ff <= CW'(SW);
      end else if (cmd.div_step && dcnt_ff != '0) begin
         if (!trial[SW]) begin
            drem_ff <= trial[SW-1:0];
            dquo_ff <= {dquo_ff[SW-2:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[SW-2:0], dquo_ff[SW-1]};
            dquo_ff <= {dquo_ff[SW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - CW'(1);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (cmd.emit || cmd.empty) begin
         out_full_ff <= 1'b1;
      end else if (cmd.out_take) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_val_ff  <= pfcm_pkg::sat32(res_ff);
         out_idx_ff  <= emitted_ff[IW-1:0];
         out_last_ff <= (emitted_ff + TW'(1)) == total;
         out_none_ff <= 1'b0;
      end else if (cmd.empty) begin
         out_val_ff  <= '0;
         out_idx_ff  <= '0;
         out_last_ff <= 1'b0;
         out_none_ff <= 1'b1;
      end
   end

   assign mapped_value    = out_val_ff;
   assign out_index       = out_idx_ff;
   assign last_of_record  = out_last_ff;
   assign nothing_pending = out_none_ff;
endmodule

FILE: tb/pfcm_scoreboard.sv
// Scoreboard class: feature crossing prediction and result checking.
class pfcm_scoreboard;
   typedef struct packed {
      logic [31:0] mapped;
      logic [12:0] index;
      logic        last;
      logic        nothing;
   } mapped_result_type;

   logic [3:0]         map_mode;
   logic [6:0]         feature_count;
   logic signed [31:0] interval_start;
   logic signed [31:0] interval_end;

   logic [31:0]        features[64];
   int unsigned        loaded;
   int unsigned        row;
   int unsigned        col;
   bit                 second;
   longint             feature_total;
   int unsigned        emitted;

   mapped_result_type  awaited[$];
   int                 errors;

   function new();
      map_mode = pfcm_pkg::MODE_AND;
      feature_count = 7'd1;
      interval_start = 0;
      interval_end = 32'sd65536;
      errors = 0;
      clear_record();
   endfunction

   function void clear_record();
      loaded = 0;
      row = 0;
      col = 0;
      second = 0;
      feature_total = 0;
      emitted = 0;
   endfunction

   function void write_reg(pfcm_pkg::csr_index_type idx, logic [31:0] value);
      case (idx)
         pfcm_pkg::CSR_MAP_MODE: begin
            map_mode = value[3:0];
            clear_record();
         end
         pfcm_pkg::CSR_FEATURE_COUNT: begin
            feature_count = value[6:0];
            clear_record();
         end
         pfcm_pkg::CSR_INTERVAL_START: interval_start = value;
         default: interval_end = value;
      endcase
   endfunction

   function int unsigned record_size();
      if (feature_count < 1) return 1;
      if (feature_count > 64) return 64;
      return feature_count;
   endfunction

   function int unsigned output_total(int unsigned n);
      case (map_mode)
         pfcm_pkg::MODE_AND, pfcm_pkg::MODE_OR, pfcm_pkg::MODE_XOR,
         pfcm_pkg::MODE_MUL, pfcm_pkg::MODE_ADD: return n * (n + 1) / 2;
         pfcm_pkg::MODE_AND_OR: return n * (n + 1);
         pfcm_pkg::MODE_AVERAGE: return n + 1;
         pfcm_pkg::MODE_NEGATE, pfcm_pkg::MODE_INTERVAL: return n;
         default: return 0;
      endcase
   endfunction

   function longint stored(int unsigned i);
      return longint'($signed(features[i % 64]));
   endfunction

   function longint whole_part(longint x);
      return (x < 0) ? 0 : (x >>> 16);
   endfunction

   // Clips to the signed 32-bit range; arithmetic shift rounds toward minus infinity, as the product shift does.
   function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Notes an accepted request and queues the result it causes, if any.
   function void note_request(bit fetch, logic [31:0] value);
      int unsigned n, total, k;
      longint a, b, v;
      mapped_result_type r;
      n = record_size();
      if (!fetch) begin
         if (loaded >= n) clear_record();
         features[loaded % 64] = value;
         loaded++;
         feature_total += longint'($signed(value));
         return;
      end
      total = output_total(n);
      r = '0;
      r.nothing = 1'b1;
      if (loaded != n || emitted >= total) begin
         awaited.push_back(r);
         return;
      end
      k = emitted;
      v = 0;
      if (map_mode <= pfcm_pkg::MODE_ADD) begin
         a = stored(row);
         b = stored(col);
         case (map_mode)
            pfcm_pkg::MODE_AND: v = (whole_part(a) & whole_part(b)) <<< 16;
            pfcm_pkg::MODE_OR: v = (whole_part(a) | whole_part(b)) <<< 16;
            pfcm_pkg::MODE_XOR: v = (whole_part(a) ^ whole_part(b)) <<< 16;
            pfcm_pkg::MODE_AND_OR:
               v = second ? ((whole_part(a) | whole_part(b)) <<< 16)
                          : ((whole_part(a) & whole_part(b)) <<< 16);
            pfcm_pkg::MODE_MUL: v = (a * b) >>> 16;
            default: v = a + b;
         endcase
         if (map_mode == pfcm_pkg::MODE_AND_OR && !second) begin
            second = 1;
         end else begin
            second = 0;
            col++;
            if (col >= n) begin
               row++;
               col = row;
            end
         end
      end else if (map_mode == pfcm_pkg::MODE_AVERAGE) begin
         if (k < n) v = stored(k);
         else v = feature_total / longint'(n);
      end else if (map_mode == pfcm_pkg::MODE_NEGATE) begin
         v = 64'sd65536 - stored(k);
      end else begin
         v = ((stored(k) * (longint'(interval_end) - longint'(interval_start))) >>> 16)
             + longint'(interval_start);
      end
      emitted++;
      r.mapped = 32'(clip32(v));
      r.index = 13'(k);
      r.last = (emitted == total);
      r.nothing = 1'b0;
      awaited.push_back(r);
   endfunction

   task report(string what);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Compares one accepted result with the oldest expectation.
   task check_result(logic [31:0] mapped, logic [12:0] index, logic last,
                     logic nothing);
      mapped_result_type e;
      if (awaited.size() == 0) begin
         report("result with no expectation waiting");
         return;
      end
      e = awaited.pop_front();
      if (mapped !== e.mapped)
         report($sformatf("mapped_value %h, expected %h", mapped, e.mapped));
      if (index !== e.index)
         report($sformatf("out_index %0d, expected %0d", index, e.index));
      if (last !== e.last)
         report($sformatf("last_of_record %b, expected %b", last, e.last));
      if (nothing !== e.nothing)
         report($sformatf("nothing_pending %b, expected %b", nothing, e.nothing));
   endtask
endclass

FILE: tb/pairwise_feature_crossing_mapper_core_tb.sv
// Testbench top: drives the feature crossing mapper and checks every result.
module pairwise_feature_crossing_mapper_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [pfcm_pkg::CSR_ADDR_W-1:0] csr_index = '0;
   logic [pfcm_pkg::VALUE_W-1:0] csr_data = '0;

   // The request carries func in bit 32 above the feature value; the result packs
   // mapped_value, out_index, last_of_record and nothing_pending from the top down.
   pfcm_if #(.W(33)) req_ch ();
   pfcm_if #(.W(47)) rsp_ch ();

   pfcm_scoreboard board;
   bit rsp_gaps_on = 1'b1;
   int long_hold = 0;   // cycles for which the receiver holds off outright

   always #5 clock = ~clock;

   pairwise_feature_crossing_mapper_core dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data));

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // Writes one register and updates the prediction alongside.
   task automatic write_reg(pfcm_pkg::csr_index_type idx, logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(idx, value);
   endtask

   // Offers one item and waits for it to be accepted; the idle gap comes first
   // so that valid never drops between back-to-back items.
   task automatic send_item(bit fetch, logic [31:0] value, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= {fetch, value};
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(fetch, value);
   endtask

   task automatic stop_sending();
      req_ch.valid <= 1'b0;
   endtask

   // Waits until every expected result has come, then lets the block settle.
   task automatic drain();
      stop_sending();
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // A random feature, mostly small positive or negative magnitudes with edge values.
   function automatic logic [31:0] rand_feature();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom();
         3: return 32'(-$signed({16'h0, $urandom_range(0, 32'h7_FFFF)}));
         default: return $urandom_range(0, 32'h3F_FFFF);
      endcase
   endfunction

   // One record loaded and then fetched, with some extra fetches or a cut-short walk.
   task automatic record_pass(int n, bit gaps);
      int total, fetches;
      for (int i = 0; i < n; i++) send_item(1'b0, rand_feature(), gaps);
      total = board.output_total(board.record_size());
      case ($urandom_range(0, 9))
         0: fetches = $urandom_range(0, total);
         1: fetches = total + $urandom_range(1, 3);
         default: fetches = total;
      endcase
      for (int i = 0; i < fetches; i++) send_item(1'b1, $urandom(), gaps);
   endtask

   // Receiver: random stalls per result, a long hold-off when asked.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.data[46:15], rsp_ch.data[14:2], rsp_ch.data[1],
                            rsp_ch.data[0]);
   end

   initial begin : receiver
      int gap;
      board = new();
      @(negedge reset);
      forever begin
         if (long_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (long_hold) @(posedge clock);
            long_hold = 0;
         end
         gap = rsp_gaps_on ? $urandom_range(0, 11) : 0;
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      int sent_random;
      int n;
      logic [31:0] m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fetch before a record is complete, every mode on a small record
      // of random features, a fetch after the last output, and reloading a full record.
      send_item(1'b1, 32'h0, 1'b0);
      drain();
      write_reg(pfcm_pkg::CSR_FEATURE_COUNT, 32'd3);
      write_reg(pfcm_pkg::CSR_INTERVAL_START, 32'h8000_0000);
      write_reg(pfcm_pkg::CSR_INTERVAL_END, 32'h7FFF_FFFF);
      send_item(1'b0, 32'h7FFF_FFFF, 1'b0);
      send_item(1'b1, 32'h0, 1'b0);
      send_item(1'b0, 32'h8000_0000, 1'b0);
      send_item(1'b0, 32'h0003_8000, 1'b0);
      for (int i = 0; i < 10; i++) send_item(1'b1, 32'hFFFF_FFFF, 1'b0);
      send_item(1'b0, 32'hFFFF_0000, 1'b0);
      drain();
      for (int md = 0; md <= 9; md++) begin
         write_reg(pfcm_pkg::CSR_MAP_MODE, md);
         n = (md == 9) ? 2 : 3;
         record_pass(n, 1'b0);
         drain();
      end
      write_reg(pfcm_pkg::CSR_MAP_MODE, 32'hF);
      record_pass(1, 1'b1);
      drain();

      // Pressure: receiver holds off while loads and fetches keep coming.
      write_reg(pfcm_pkg::CSR_MAP_MODE, 32'(pfcm_pkg::MODE_MUL));
      write_reg(pfcm_pkg::CSR_FEATURE_COUNT, 32'd4);
      long_hold = 300;
      record_pass(4, 1'b0);
      drain();

      // Random phases through several settings, the extremes among them.
      sent_random = 0;
      while (sent_random < 900) begin
         m = $urandom_range(0, 9);
         write_reg(pfcm_pkg::CSR_MAP_MODE, (m == 9) ? $urandom_range(9, 15) : m);
         case ($urandom_range(0, 9))
            0: n = 64;
            1: n = 1;
            2: n = $urandom_range(65, 127);
            3: n = 0;
            default: n = $urandom_range(2, 8);
         endcase
         write_reg(pfcm_pkg::CSR_FEATURE_COUNT, n);
         case ($urandom_range(0, 3))
            0: begin
               write_reg(pfcm_pkg::CSR_INTERVAL_START, 32'h8000_0000);
               write_reg(pfcm_pkg::CSR_INTERVAL_END, 32'h7FFF_FFFF);
            end
            1: begin
               write_reg(pfcm_pkg::CSR_INTERVAL_START, 32'h0);
               write_reg(pfcm_pkg::CSR_INTERVAL_END, 32'h0001_0000);
            end
            default: begin
               write_reg(pfcm_pkg::CSR_INTERVAL_START, $urandom());
               write_reg(pfcm_pkg::CSR_INTERVAL_END, $urandom());
            end
         endcase
         rsp_gaps_on = $urandom_range(0, 3) != 0;
         n = board.record_size();
         // Large records only in the cheap modes, to keep the run short.
         if (n > 8 && board.output_total(n) > 200) begin
            write_reg(pfcm_pkg::CSR_FEATURE_COUNT, 32'd8);
            n = 8;
         end
         for (int r = 0; r < 2; r++) begin
            record_pass(n, $urandom_range(0, 2) != 0);
            sent_random += n + board.output_total(n);
            if ($urandom_range(0, 4) == 0) begin
               send_item(1'($urandom_range(0, 1)), rand_feature(), 1'b1);
               sent_random++;
            end
         end
         drain();
      end

      drain();
      if (board.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: filelist.f
src/pfcm_pkg.sv
src/pfcm_if.sv
src/pfcm_ctrl.sv
src/pfcm_dp.sv
src/pairwise_feature_crossing_mapper_core.sv
tb/pfcm_scoreboard.sv
tb/pairwise_feature_crossing_mapper_core_tb.sv
